[hdl/bba_pkg.sv]
package bba_pkg;

  // Bitmap word geometry
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned BIT_W   = 6;
  localparam int unsigned BLK_W   = 12;
  localparam int unsigned LIM_W   = 13;
  localparam int unsigned SPAN    = 4096;

  // Request codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EVAL
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic eval;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_ready;
  } dp_status_t;

endpackage

[hdl/bitmap_block_allocator_core.sv]
// First-fit block allocator over a bitmap of used flags.
// Input channel (in_valid_i / in_stall_o): cmd_i = alloc or free, block_i = block to free.
// An item is taken at an edge with in_valid_i high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i): one result item per request,
// block_out_o = allocated block (0 when none) or echo of the freed block,
// status_o = ok, no free block, already free, or out of range.
// Result path: the accepting edge captures the request, the lookup state reads the bitmap
// word, and the eval state writes it back and loads the output register (out_valid_o).
// Items are not overlapped: in_stall_o stays high from acceptance until evaluation; the
// single-port bitmap RAM (64-bit words) is read, then written at most once per item. A
// flag per word marks it fully used, so the lowest free block is found by one priority
// encode over the word flags and one over the word read. Reset: all blocks free (words
// never written read as zero), total_blocks = 4096. No clearing pass is needed. The user
// must write total_blocks (cfg_we_i) only while idle; the block has no guard for this.
// Receiver stall: the result holds in the output register; the next item is still
// accepted and worked up to evaluation, where it waits until the register frees.
module bitmap_block_allocator_core import bba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  input  logic [BLK_W-1:0] block_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [BLK_W-1:0] block_out_o,
  output logic [1:0]       status_o,
  input  logic             cfg_we_i,
  input  logic [LIM_W-1:0] cfg_wdata_i
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  // sequencer: idle -> lookup (RAM read) -> eval (write back, load result)
  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .dp_status_i (dp_status),
    .ctrl_cmd_o  (ctrl_cmd)
  );

  // bitmap RAM, word flags, limit register and output register
  bba_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_cmd_i  (ctrl_cmd),
    .dp_status_o (dp_status),
    .cmd_i       (cmd_i),
    .block_i     (block_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .block_out_o (block_out_o),
    .status_o    (status_o)
  );

endmodule

[hdl/bba_ctrl.sv]
module bba_ctrl import bba_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t dp_status_i,
  output ctrl_cmd_t  ctrl_cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_cmd_o.capture = 1'b1;
          state_d            = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        ctrl_cmd_o.lookup = 1'b1;
        state_d           = S_EVAL;
      end
      S_EVAL: begin
        // wait for room in the output register
        if (dp_status_i.out_ready) begin
          ctrl_cmd_o.eval = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/bba_datapath.sv]
module bba_datapath import bba_pkg::*; #(
  parameter int unsigned NUM_BLOCKS = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        ctrl_cmd_i,
  output dp_status_t       dp_status_o,
  input  logic             cmd_i,
  input  logic [BLK_W-1:0] block_i,
  input  logic             cfg_we_i,
  input  logic [LIM_W-1:0] cfg_wdata_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [BLK_W-1:0] block_out_o,
  output logic [1:0]       status_o
);

  localparam int unsigned EFF   = (NUM_BLOCKS < SPAN) ? NUM_BLOCKS : SPAN;
  localparam int unsigned WORDS = (EFF + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [LIM_W-1:0] EffLim = LIM_W'(EFF);

  // bitmap memory, per-word written flag and all-used flag
  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic [WORDS-1:0]  wvalid_q, wvalid_d;
  logic [WORDS-1:0]  full_q, full_d;

  logic [LIM_W-1:0]  total_q;
  logic              cmd_q;
  logic [BLK_W-1:0]  blk_q;
  logic [AW-1:0]     idx_q;
  logic              found_q;

  logic              out_valid_q;
  logic [BLK_W-1:0]  block_out_q;
  status_e           status_q;

  // lookup-stage signals
  logic [AW-1:0]     first_idx;
  logic              first_found;
  logic [AW-1:0]     rd_idx;

  // eval-stage signals
  logic [LIM_W-1:0]  lim;
  logic [WORD_W-1:0] word;
  logic [BIT_W-1:0]  free_pos;
  logic [LIM_W-1:0]  cand;
  logic              alloc_ok;
  logic              in_range;
  logic              cur_bit;
  logic              wr_en;
  logic [WORD_W-1:0] wr_data;
  logic [BLK_W-1:0]  res_block;
  status_e           res_status;

  assign dp_status_o.out_ready = !out_valid_q || !out_stall_i;

  // first word that still holds a free bit
  always_comb begin
    first_idx   = '0;
    first_found = 1'b0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (!full_q[i]) begin
        first_idx   = AW'(i);
        first_found = 1'b1;
      end
    end
  end

  assign rd_idx = (cmd_q == CMD_ALLOC) ? first_idx : blk_q[BIT_W +: AW];

  always_comb begin
    lim = (total_q < EffLim) ? total_q : EffLim;
    word = wvalid_q[idx_q] ? rdata_q : '0;
  end

  // lowest clear bit of the word
  always_comb begin
    free_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!word[b]) begin
        free_pos = BIT_W'(b);
      end
    end
  end

  always_comb begin
    cand       = LIM_W'({idx_q, free_pos});
    alloc_ok   = found_q && (cand < lim);
    in_range   = ({1'b0, blk_q} < lim);
    cur_bit    = word[blk_q[BIT_W-1:0]];
    wr_en      = 1'b0;
    wr_data    = word;
    res_block  = '0;
    res_status = ST_OK;
    wvalid_d   = wvalid_q;
    full_d     = full_q;
    if (cmd_q == CMD_ALLOC) begin
      if (alloc_ok) begin
        wr_en     = 1'b1;
        wr_data   = word | (WORD_W'(1) << free_pos);
        res_block = cand[BLK_W-1:0];
      end else begin
        res_status = ST_FULL;
      end
    end else begin
      res_block = blk_q;
      if (!in_range) begin
        res_status = ST_RANGE;
      end else if (!cur_bit) begin
        res_status = ST_ALREADY_FREE;
      end else begin
        wr_en   = 1'b1;
        wr_data = word & ~(WORD_W'(1) << blk_q[BIT_W-1:0]);
      end
    end
    if (ctrl_cmd_i.eval && wr_en) begin
      wvalid_d[idx_q] = 1'b1;
      full_d[idx_q]   = &wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.lookup) begin
      rdata_q <= mem[rd_idx];
    end
    if (ctrl_cmd_i.eval && wr_en) begin
      mem[idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q    <= '0;
      full_q      <= '0;
      total_q     <= LIM_W'(SPAN);
      out_valid_q <= 1'b0;
    end else begin
      wvalid_q <= wvalid_d;
      full_q   <= full_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (ctrl_cmd_i.eval) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_cmd_i.capture) begin
      cmd_q <= cmd_i;
      blk_q <= block_i;
    end
    if (ctrl_cmd_i.lookup) begin
      idx_q   <= rd_idx;
      found_q <= first_found;
    end
    if (ctrl_cmd_i.eval) begin
      block_out_q <= res_block;
      status_q    <= res_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign block_out_o = block_out_q;
  assign status_o    = status_q;

endmodule
